@@ design/rwhp_pkg.sv @@
// shared types, constants and helpers for the riff wave header parser
package rwhp_pkg;

  localparam int unsigned OUT_TDATA_W = 168;
  localparam int unsigned CAP_DEPTH   = 24;

  localparam logic [31:0] TEXT_RIFF = 32'h5249_4646;
  localparam logic [31:0] TEXT_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT   = 32'h464D_5420;
  localparam logic [31:0] TAG_DATA  = 32'h4441_5441;

  localparam logic [15:0] FMT_TAG_PCM = 16'h0001;
  localparam logic [15:0] FMT_TAG_EXT = 16'hFFFE;

  // bit positions of the result fields in m_axis_tdata
  localparam int unsigned POS_STATUS = 0;
  localparam int unsigned POS_FMT    = 1;
  localparam int unsigned POS_CHAN   = 3;
  localparam int unsigned POS_RATE   = 19;
  localparam int unsigned POS_BITS   = 51;
  localparam int unsigned POS_MASK   = 67;
  localparam int unsigned POS_OFFSET = 99;
  localparam int unsigned POS_SIZE   = 131;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_CHUNK  = 3'd1,
    PH_FMT    = 3'd2,
    PH_SKIP   = 3'd3,
    PH_IGNORE = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_PCM  = 2'd1,
    KIND_EXT  = 2'd2
  } kind_e;

  typedef struct packed {
    logic        status;
    kind_e       format_type;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] bits_per_sample;
    logic [31:0] channel_mask;
    logic [31:0] data_offset;
    logic [31:0] data_size;
  } result_t;

  function automatic logic [7:0] upper_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h61 && b <= 8'h7A) r = b - 8'h20;
    return r;
  endfunction

  // character i of a four-character text, first character in the top byte
  function automatic logic [7:0] text_char(input logic [31:0] text, input logic [1:0] i);
    return text[{~i, 3'b000} +: 8];
  endfunction

endpackage

@@ design/riff_wave_header_parser.sv @@
// top level of the riff wave header parser
//
// a wav file enters on the slave stream one byte per item, in file order,
// with tlast on the final byte. the header is checked for riff and wave,
// chunk headers are walked, the fmt chunk is decoded and the last data
// chunk's body offset and size are kept.
// one result item leaves on the master stream for each file, carrying
// status, format fields and data chunk position; no result for other bytes.
// throughput is one byte per cycle while no last byte waits on a stall;
// the per-byte work is a single pass of logic between the input register
// and the parse state; a tlast byte's result loads into the result register.
// reset clears the parse state, the input valid and the result valid.
// when the receiver stalls, the result register holds; bytes that are not
// the last keep flowing, and a last byte waits in the input register, which
// drops s_axis_tready once it is full and blocked.
// after each last byte the parser returns to its reset state for a new file.
module riff_wave_header_parser
  import rwhp_pkg::*;
#(
  parameter int unsigned FMT_MAX_BYTES = 40
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // data_byte
  input  logic                   s_axis_tlast,   // last_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status, format_type, channel_count, sample_rate, bits_per_sample,
  // channel_mask, data_offset, data_size, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       load_ok;
  logic       advance;
  result_t    result;

  assign advance       = in_valid_q & (~in_last_q | load_ok);
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  rwhp_parse #(
    .FMT_MAX_BYTES(FMT_MAX_BYTES)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (advance),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .result_o(result)
  );

  rwhp_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance & in_last_q),
    .result_i     (result),
    .load_ok_o    (load_ok),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule

@@ design/rwhp_parse.sv @@
// byte-wise riff wave parse state, fmt capture and result build
module rwhp_parse
  import rwhp_pkg::*;
#(
  parameter int unsigned FMT_MAX_BYTES = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output result_t     result_o
);

  localparam int unsigned IdxW = $clog2(FMT_MAX_BYTES + 1);

  phase_e          phase_q, phase_d;
  logic [31:0]     pos_q, pos_d;
  logic [IdxW-1:0] idx_q, idx_d, idx_inc;
  logic            matched_q, matched_d;
  logic [31:0]     tag_q, tag_d;
  logic [31:0]     len_q, len_d;
  logic [32:0]     rem_q, rem_d;
  logic [7:0]      cap_q [CAP_DEPTH];
  logic [7:0]      cap_n [CAP_DEPTH];
  logic            cap_clear;
  kind_e           kind_q, kind_d;
  logic [15:0]     chan_q, chan_d;
  logic [31:0]     rate_q, rate_d;
  logic [15:0]     bits_q, bits_d;
  logic [31:0]     mask_q, mask_d;
  logic [31:0]     dstart_q, dstart_d;
  logic [31:0]     dlen_q, dlen_d;
  logic [7:0]      ub;
  logic [15:0]     fmt_tag;
  logic [32:0]     padded;
  logic            ok;

  assign ub      = upper_case(byte_i);
  assign idx_inc = idx_q + 1'b1;
  assign padded  = {1'b0, len_d} + {32'd0, len_d[0]};
  assign fmt_tag = {cap_n[1], cap_n[0]};

  always_comb begin
    phase_d   = phase_q;
    pos_d     = pos_q + 32'd1;
    idx_d     = idx_q;
    matched_d = matched_q;
    tag_d     = tag_q;
    len_d     = len_q;
    rem_d     = rem_q;
    kind_d    = kind_q;
    chan_d    = chan_q;
    rate_d    = rate_q;
    bits_d    = bits_q;
    mask_d    = mask_q;
    dstart_d  = dstart_q;
    dlen_d    = dlen_q;
    cap_clear = 1'b0;
    cap_n     = cap_q;
    unique case (phase_q)
      PH_HEADER: begin
        if (idx_q < IdxW'(4)) begin
          if (ub != text_char(TEXT_RIFF, idx_q[1:0])) matched_d = 1'b0;
        end else if (idx_q >= IdxW'(8) && idx_q < IdxW'(12)) begin
          if (ub != text_char(TEXT_WAVE, idx_q[1:0])) matched_d = 1'b0;
        end
        idx_d = idx_inc;
        if (idx_inc == IdxW'(12)) begin
          idx_d   = '0;
          phase_d = matched_d ? PH_CHUNK : PH_IGNORE;
        end
      end
      PH_CHUNK: begin
        if (idx_q < IdxW'(4)) begin
          tag_d = {tag_q[23:0], ub};
        end else if (idx_q == IdxW'(4)) begin
          len_d = {24'd0, byte_i};
        end else begin
          len_d[{idx_q[1:0], 3'b000} +: 8] = byte_i;
        end
        idx_d = idx_inc;
        if (idx_q == IdxW'(7)) begin
          idx_d = '0;
          if (tag_q == TAG_FMT && len_d <= 32'(FMT_MAX_BYTES)) begin
            cap_clear = 1'b1;
            phase_d   = (len_d == 32'd0) ? PH_CHUNK : PH_FMT;
          end else begin
            if (tag_q == TAG_DATA) begin
              dlen_d   = len_d;
              dstart_d = pos_q + 32'd1;
            end
            rem_d   = padded;
            phase_d = (padded == 33'd0) ? PH_CHUNK : PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        if (idx_q < IdxW'(CAP_DEPTH)) cap_n[idx_q[4:0]] = byte_i;
        idx_d = idx_inc;
        if (32'(idx_inc) >= len_q) begin
          if (fmt_tag == FMT_TAG_PCM || fmt_tag == FMT_TAG_EXT) begin
            kind_d = (fmt_tag == FMT_TAG_PCM) ? KIND_PCM : KIND_EXT;
            chan_d = {cap_n[3], cap_n[2]};
            rate_d = {cap_n[7], cap_n[6], cap_n[5], cap_n[4]};
            bits_d = {cap_n[15], cap_n[14]};
            mask_d = (fmt_tag == FMT_TAG_PCM) ? 32'd0
                   : {cap_n[23], cap_n[22], cap_n[21], cap_n[20]};
          end
          idx_d   = '0;
          rem_d   = {32'd0, len_q[0]};
          phase_d = len_q[0] ? PH_SKIP : PH_CHUNK;
        end
      end
      PH_SKIP: begin
        rem_d = rem_q - {32'd0, (rem_q != 33'd0)};
        if (rem_d == 33'd0) begin
          phase_d = PH_CHUNK;
          idx_d   = '0;
        end
      end
      PH_IGNORE: ;
      default: ;
    endcase
  end

  assign ok = matched_d && phase_d != PH_HEADER && phase_d != PH_IGNORE &&
              kind_d != KIND_NONE && dlen_d != 32'd0 && dstart_d != 32'd0;

  always_comb begin
    result_o.status          = ~ok;
    result_o.format_type     = kind_d;
    result_o.channel_count   = chan_d;
    result_o.sample_rate     = rate_d;
    result_o.bits_per_sample = bits_d;
    result_o.channel_mask    = mask_d;
    result_o.data_offset     = dstart_d;
    result_o.data_size       = dlen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      pos_q     <= '0;
      idx_q     <= '0;
      matched_q <= 1'b1;
      tag_q     <= '0;
      len_q     <= '0;
      rem_q     <= '0;
      kind_q    <= KIND_NONE;
      chan_q    <= '0;
      rate_q    <= '0;
      bits_q    <= '0;
      mask_q    <= '0;
      dstart_q  <= '0;
      dlen_q    <= '0;
    end else if (take_i) begin
      if (last_i) begin
        phase_q   <= PH_HEADER;
        pos_q     <= '0;
        idx_q     <= '0;
        matched_q <= 1'b1;
        tag_q     <= '0;
        len_q     <= '0;
        rem_q     <= '0;
        kind_q    <= KIND_NONE;
        chan_q    <= '0;
        rate_q    <= '0;
        bits_q    <= '0;
        mask_q    <= '0;
        dstart_q  <= '0;
        dlen_q    <= '0;
      end else begin
        phase_q   <= phase_d;
        pos_q     <= pos_d;
        idx_q     <= idx_d;
        matched_q <= matched_d;
        tag_q     <= tag_d;
        len_q     <= len_d;
        rem_q     <= rem_d;
        kind_q    <= kind_d;
        chan_q    <= chan_d;
        rate_q    <= rate_d;
        bits_q    <= bits_d;
        mask_q    <= mask_d;
        dstart_q  <= dstart_d;
        dlen_q    <= dlen_d;
      end
    end
  end

  // capture bytes are cleared at each fmt chunk header before use
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      for (int i = 0; i < CAP_DEPTH; i++) begin
        cap_q[i] <= cap_clear ? 8'd0 : cap_n[i];
      end
    end
  end

endmodule

@@ design/rwhp_out.sv @@
// result register and master-side stream handshake
module rwhp_out
  import rwhp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  result_t                result_i,
  output logic                   load_ok_o,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic    valid_q;
  result_t res_q;

  assign load_ok_o     = ~valid_q | m_axis_tready;
  assign m_axis_tvalid = valid_q;

  assign m_axis_tdata = {5'd0, res_q.data_size, res_q.data_offset, res_q.channel_mask,
                         res_q.bits_per_sample, res_q.sample_rate, res_q.channel_count,
                         res_q.format_type, res_q.status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ok_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && load_ok_o) begin
      res_q <= result_i;
    end
  end

endmodule

@@ design/rwhp_checker.sv @@
// port-level checks for the riff wave header parser, bound to the top level
module rwhp_checker
  import rwhp_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [1:0]  fmt_type;
  logic [31:0] mask;
  logic [31:0] offset;
  logic [31:0] size;

  assign fmt_type = m_axis_tdata[POS_FMT +: 2];
  assign mask     = m_axis_tdata[POS_MASK +: 32];
  assign offset   = m_axis_tdata[POS_OFFSET +: 32];
  assign size     = m_axis_tdata[POS_SIZE +: 32];

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // good status needs a kept format and a placed data chunk
  a_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[POS_STATUS] |->
      fmt_type != 2'd0 && size != 32'd0 && offset != 32'd0)
    else $error("good status without format or data chunk");

  a_fmt_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> fmt_type != 2'd3)
    else $error("bad format type code");

  // speaker mask only for extensible format
  a_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && fmt_type != 2'd2 |-> mask == 32'd0)
    else $error("channel mask without extensible format");

  a_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid && s_axis_tready)
    else $error("not idle after reset");

  logic unused_ok;
  assign unused_ok = s_axis_tvalid;

endmodule

bind riff_wave_header_parser rwhp_checker u_rwhp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

@@ test/tb_riff_wave_header_parser.sv @@
// testbench for the riff wave header parser: wav files sent byte by byte, summaries checked
module tb_riff_wave_header_parser;
  import rwhp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned FMT_LIMIT     = 40;
  localparam int unsigned RESULT_LAT    = 4;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned RANDOM_FILES  = 3;
  localparam int unsigned CYCLE_LIMIT   = 500000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // data_byte
  logic s_axis_tlast = 1'b0;          // last_byte
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b1;
  // status, format_type, channel_count, sample_rate, bits_per_sample,
  // channel_mask, data_offset, data_size, zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  riff_wave_header_parser #(
    .FMT_MAX_BYTES(FMT_LIMIT)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // parser state as predicted
  phase_e      parse_ph;
  logic [31:0] file_pos;
  int unsigned hdr_idx;
  logic        header_ok;
  logic [31:0] cur_tag;
  logic [31:0] cur_len;
  logic [32:0] bytes_to_skip;
  logic [7:0]  fmt_bytes [CAP_DEPTH];
  kind_e       fmt_kind;
  logic [15:0] fmt_channels;
  logic [31:0] fmt_rate;
  logic [15:0] fmt_bits;
  logic [31:0] fmt_mask;
  logic [31:0] body_start;
  logic [31:0] body_len;

  result_t     wav_summaries [$];
  logic [7:0]  wav_file [$];

  int unsigned bytes_sent = 0;
  int unsigned files_sent = 0;
  int unsigned results_seen = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          src_idle = 1'b1;
  bit          sink_idle = 1'b1;
  bit          long_hold_req = 1'b0;
  bit          hold_active = 1'b0;

  function automatic logic [7:0] fold_case(logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) ? b - 8'h20 : b;
  endfunction

  function automatic logic [31:0] fmt_le(int unsigned at, int unsigned n);
    logic [31:0] v;
    v = '0;
    for (int unsigned i = 0; i < n; i++) v |= 32'(fmt_bytes[at + i]) << (8 * i);
    return v;
  endfunction

  task automatic reset_parser();
    parse_ph      = PH_HEADER;
    file_pos      = '0;
    hdr_idx       = 0;
    header_ok     = 1'b1;
    cur_tag       = '0;
    cur_len       = '0;
    bytes_to_skip = '0;
    foreach (fmt_bytes[i]) fmt_bytes[i] = '0;
    fmt_kind      = KIND_NONE;
    fmt_channels  = '0;
    fmt_rate      = '0;
    fmt_bits      = '0;
    fmt_mask      = '0;
    body_start    = '0;
    body_len      = '0;
  endtask

  task automatic begin_skip(logic [32:0] count);
    bytes_to_skip = count;
    parse_ph      = (count == 0) ? PH_CHUNK : PH_SKIP;
    hdr_idx       = 0;
  endtask

  task automatic close_fmt();
    logic [15:0] tag;
    tag = fmt_le(0, 2);
    if (tag == FMT_TAG_PCM || tag == FMT_TAG_EXT) begin
      fmt_kind     = (tag == FMT_TAG_PCM) ? KIND_PCM : KIND_EXT;
      fmt_channels = fmt_le(2, 2);
      fmt_rate     = fmt_le(4, 4);
      fmt_bits     = fmt_le(14, 2);
      fmt_mask     = (tag == FMT_TAG_PCM) ? 32'd0 : fmt_le(20, 4);
    end
    begin_skip({32'd0, cur_len[0]});
  endtask

  task automatic end_chunk_header();
    if (cur_tag == TAG_FMT && cur_len <= FMT_LIMIT) begin
      foreach (fmt_bytes[i]) fmt_bytes[i] = '0;
      hdr_idx = 0;
      if (cur_len == 0) close_fmt();
      else parse_ph = PH_FMT;
    end else begin
      if (cur_tag == TAG_DATA) begin
        body_len   = cur_len;
        body_start = file_pos + 1;
      end
      begin_skip({1'b0, cur_len} + cur_len[0]);
    end
  endtask

  task automatic parse_wav_byte(logic [7:0] b, logic last);
    result_t summary;
    case (parse_ph)
      PH_HEADER: begin
        if (hdr_idx < 4) begin
          if (fold_case(b) != TEXT_RIFF[8 * (3 - hdr_idx) +: 8]) header_ok = 1'b0;
        end else if (hdr_idx >= 8 && hdr_idx < 12) begin
          if (fold_case(b) != TEXT_WAVE[8 * (11 - hdr_idx) +: 8]) header_ok = 1'b0;
        end
        hdr_idx++;
        if (hdr_idx >= 12) begin
          hdr_idx  = 0;
          parse_ph = header_ok ? PH_CHUNK : PH_IGNORE;
        end
      end
      PH_CHUNK: begin
        if (hdr_idx < 4) begin
          cur_tag = {cur_tag[23:0], fold_case(b)};
        end else begin
          if (hdr_idx == 4) cur_len = '0;
          cur_len |= 32'(b) << (8 * (hdr_idx - 4));
        end
        hdr_idx++;
        if (hdr_idx >= 8) end_chunk_header();
      end
      PH_FMT: begin
        if (hdr_idx < CAP_DEPTH) fmt_bytes[hdr_idx] = b;
        hdr_idx++;
        if (hdr_idx >= cur_len) close_fmt();
      end
      PH_SKIP: begin
        if (bytes_to_skip > 0) bytes_to_skip--;
        if (bytes_to_skip == 0) begin
          parse_ph = PH_CHUNK;
          hdr_idx  = 0;
        end
      end
      default: ;
    endcase
    file_pos++;
    if (last) begin
      summary.status = !(header_ok && parse_ph != PH_HEADER && parse_ph != PH_IGNORE &&
                         fmt_kind != KIND_NONE && body_len != 0 && body_start != 0);
      summary.format_type     = fmt_kind;
      summary.channel_count   = fmt_channels;
      summary.sample_rate     = fmt_rate;
      summary.bits_per_sample = fmt_bits;
      summary.channel_mask    = fmt_mask;
      summary.data_offset     = body_start;
      summary.data_size       = body_len;
      wav_summaries.push_back(summary);
      reset_parser();
    end
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    if (src_idle && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    parse_wav_byte(b, last);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_file();
    int unsigned n;
    n = wav_file.size();
    for (int unsigned i = 0; i < n; i++) send_byte(wav_file[i], i == n - 1);
    files_sent++;
    wav_file.delete();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (wav_summaries.size() != 0) @(negedge clk_i);
    repeat (RESULT_LAT) @(negedge clk_i);
  endtask

  function automatic string mix_case(string s);
    string r;
    byte c;
    r = s;
    for (int i = 0; i < r.len(); i++) begin
      c = r.getc(i);
      if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(0, 1))
        r.putc(i, c ^ 8'h20);
    end
    return r;
  endfunction

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) wav_file.push_back(s.getc(i));
  endtask

  task automatic add_le(logic [31:0] v, int unsigned n);
    for (int unsigned i = 0; i < n; i++) wav_file.push_back(v[8 * i +: 8]);
  endtask

  task automatic add_wave_header(string riff, string wave);
    add_text(riff);
    add_le($urandom(), 4);
    add_text(wave);
  endtask

  task automatic add_chunk(string tag, logic [31:0] len, int unsigned body_n);
    add_text(tag);
    add_le(len, 4);
    repeat (body_n) wav_file.push_back(8'($urandom()));
    if (body_n == len && len[0]) wav_file.push_back(8'($urandom()));
  endtask

  task automatic add_fmt(logic [15:0] tag, logic [31:0] len, logic [15:0] ch,
                         logic [31:0] rate, logic [15:0] bits, logic [31:0] mask);
    logic [191:0] body;
    body = {mask, $urandom(), bits, 16'($urandom()), $urandom(), rate, ch, tag};
    add_text(mix_case("fmt "));
    add_le(len, 4);
    for (int unsigned i = 0; i < len; i++)
      wav_file.push_back((i < CAP_DEPTH) ? body[8 * i +: 8] : 8'($urandom()));
    if (len[0]) wav_file.push_back(8'($urandom()));
  endtask

  task automatic add_pcm_fmt();
    add_fmt(FMT_TAG_PCM, 16, 16'd2, 32'd48000, 16'd24, 32'h0);
  endtask

  task automatic add_random_fmt();
    logic [15:0] tag;
    logic [31:0] len;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      tag = FMT_TAG_PCM;
      case ($urandom_range(0, 3))
        0, 1: len = 16;
        2: len = 18;
        default: len = $urandom_range(0, 44);
      endcase
    end else if (sel < 8) begin
      tag = FMT_TAG_EXT;
      len = $urandom_range(0, 1) ? FMT_LIMIT : $urandom_range(14, FMT_LIMIT + 2);
    end else begin
      tag = $urandom();
      len = $urandom_range(0, 44);
    end
    add_fmt(tag, len, $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic add_random_data();
    logic [31:0] len;
    case ($urandom_range(0, 9))
      0: add_chunk(mix_case("data"), 0, 0);
      1: begin
        len = $urandom();
        add_chunk(mix_case("data"), len, $urandom_range(0, 4));
      end
      default: begin
        len = $urandom_range(1, 8);
        add_chunk(mix_case("data"), len, len);
      end
    endcase
  endtask

  task automatic add_filler_chunk();
    string t;
    logic [31:0] len;
    t = mix_case("LIST");
    if ($urandom_range(0, 1))
      for (int i = 0; i < 4; i++) t.putc(i, 8'($urandom_range(1, 255)));
    len = $urandom_range(0, 9);
    add_chunk(t, len, len);
  endtask

  task automatic build_random_file();
    int unsigned pick;
    int unsigned idx;
    bit data_first;
    pick = $urandom_range(0, 99);
    if (pick < 90) begin
      add_wave_header(mix_case("RIFF"), mix_case("WAVE"));
      if ($urandom_range(0, 3) == 0) add_filler_chunk();
      data_first = ($urandom_range(0, 4) == 0);
      if (data_first) add_random_data();
      add_random_fmt();
      if ($urandom_range(0, 3) == 0) add_filler_chunk();
      if (!data_first || $urandom_range(0, 2) == 0) add_random_data();
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, wav_file.size() - 1)) void'(wav_file.pop_back());
      if (pick >= 80) begin
        // broken header
        idx = $urandom_range(0, 7);
        if (idx >= 4) idx += 4;
        if (idx < wav_file.size()) wav_file[idx] ^= 8'(1 << $urandom_range(0, 7));
      end
    end else begin
      repeat ($urandom_range(1, 16)) wav_file.push_back(8'($urandom()));
    end
  endtask

  task automatic test_header_checks();
    wav_file.push_back(8'h00);
    send_file();
    add_text("RIFF");
    add_le(32'h0, 4);
    add_text("WAV");
    send_file();
    add_wave_header("riff", "wave");
    add_fmt(FMT_TAG_PCM, 16, 16'd2, 32'd44100, 16'd16, 32'h0);
    add_chunk("data", 4, 4);
    send_file();
    add_wave_header("RIFX", "WAVE");
    add_pcm_fmt();
    add_chunk("data", 4, 4);
    send_file();
    add_wave_header("RIFF", "WAVF");
    add_pcm_fmt();
    add_chunk("data", 4, 4);
    send_file();
    add_wave_header("RiFf", "WavE");
    send_file();
    drain();
  endtask

  task automatic test_fmt_chunks();
    add_wave_header("RIFF", "WAVE");
    add_fmt(FMT_TAG_PCM, 16, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    add_chunk("data", 2, 2);
    send_file();
    add_wave_header("RIFF", "WAVE");
    add_fmt(FMT_TAG_EXT, FMT_LIMIT, 16'h0, 32'h0, 16'h0, 32'hFFFF_FFFF);
    add_chunk("data", 1, 1);
    send_file();
    // empty fmt
    add_wave_header("RIFF", "WAVE");
    add_fmt(FMT_TAG_PCM, 0, 16'h1, 32'h1, 16'h1, 32'h1);
    add_chunk("data", 4, 4);
    send_file();
    // short fmt, odd fmt with pad byte
    add_wave_header("RIFF", "WAVE");
    add_fmt(FMT_TAG_PCM, 3, 16'h1234, 32'h5678_9ABC, 16'h8, 32'h0);
    add_chunk("data", 4, 4);
    send_file();
    add_wave_header("RIFF", "WAVE");
    add_fmt(FMT_TAG_EXT, 23, 16'h6, 32'd96000, 16'd32, 32'hA5C3_0F81);
    add_chunk("data", 4, 4);
    send_file();
    // oversized fmt is skipped
    add_wave_header("RIFF", "WAVE");
    add_fmt(FMT_TAG_EXT, FMT_LIMIT + 1, 16'h8, 32'd8000, 16'd8, 32'h3F);
    add_chunk("data", 4, 4);
    send_file();
    // unknown tag keeps earlier fields, pcm after extensible clears the mask
    add_wave_header("RIFF", "WAVE");
    add_fmt(FMT_TAG_EXT, 24, 16'h2, 32'd22050, 16'd12, 32'h3);
    add_fmt(16'h0003, 16, 16'h9, 32'd1, 16'd64, 32'h0);
    add_chunk("data", 4, 4);
    send_file();
    add_wave_header("RIFF", "WAVE");
    add_fmt(FMT_TAG_EXT, FMT_LIMIT, 16'h4, 32'd32000, 16'd20, 32'h33);
    add_fmt(FMT_TAG_PCM, 16, 16'h1, 32'd11025, 16'd8, 32'hFF);
    add_chunk("data", 4, 4);
    send_file();
    // fmt body cut off by the end of the file
    add_wave_header("RIFF", "WAVE");
    add_pcm_fmt();
    add_chunk("data", 2, 2);
    add_chunk("fmt ", 16, 5);
    send_file();
    drain();
  endtask

  task automatic test_data_chunks();
    add_wave_header("RIFF", "WAVE");
    add_pcm_fmt();
    add_chunk("data", 0, 0);
    send_file();
    // later data chunk replaces earlier one
    add_wave_header("RIFF", "WAVE");
    add_chunk("data", 3, 3);
    add_pcm_fmt();
    add_chunk("DATA", 5, 5);
    send_file();
    add_wave_header("RIFF", "WAVE");
    add_chunk("LIST", 5, 5);
    add_pcm_fmt();
    add_chunk("JUNK", 0, 0);
    add_chunk("data", 6, 6);
    send_file();
    add_wave_header("RIFF", "WAVE");
    add_pcm_fmt();
    add_chunk("data", 32'hFFFF_FFFF, 3);
    send_file();
    // file ends on the data chunk header
    add_wave_header("RIFF", "WAVE");
    add_pcm_fmt();
    add_chunk("data", 8, 0);
    send_file();
    // partial chunk header at the end
    add_wave_header("RIFF", "WAVE");
    add_pcm_fmt();
    add_chunk("data", 2, 2);
    add_text("LIS");
    send_file();
    drain();
  endtask

  task automatic test_receiver_hold();
    long_hold_req = 1'b1;
    while (!hold_active) @(negedge clk_i);
    repeat (6) begin
      wav_file.push_back(8'($urandom()));
      send_file();
    end
    add_wave_header("RIFF", "WAVE");
    add_pcm_fmt();
    add_chunk("data", 3, 3);
    send_file();
    drain();
  endtask

  task automatic test_random_files();
    int unsigned n_files;
    n_files = 0;
    while (n_files < RANDOM_FILES) begin
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      build_random_file();
      send_file();
      n_files++;
    end
  endtask

  task automatic test_final_stretch();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    repeat (2) begin
      build_random_file();
      send_file();
    end
    drain();
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      if (error_count < 10)
        $display("%s mismatch in result %0d: expected 0x%0h, got 0x%0h",
                 what, results_seen, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    logic [OUT_TDATA_W-1:0] got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (wav_summaries.size() == 0) begin
        if (error_count < 10) $display("result item with no file pending: 0x%0h", got);
        error_count++;
      end else begin
        want = wav_summaries.pop_front();
        check_field("status", want.status, got[POS_STATUS]);
        check_field("format_type", want.format_type, got[POS_FMT +: 2]);
        check_field("channel_count", want.channel_count, got[POS_CHAN +: 16]);
        check_field("sample_rate", want.sample_rate, got[POS_RATE +: 32]);
        check_field("bits_per_sample", want.bits_per_sample, got[POS_BITS +: 16]);
        check_field("channel_mask", want.channel_mask, got[POS_MASK +: 32]);
        check_field("data_offset", want.data_offset, got[POS_OFFSET +: 32]);
        check_field("data_size", want.data_size, got[POS_SIZE +: 32]);
        check_field("zero fill", '0, got[OUT_TDATA_W-1:POS_SIZE+32]);
      end
      results_seen++;
    end
  end

  initial begin : result_sink
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        m_axis_tready <= 1'b0;
        hold_active = 1'b1;
        for (int n = 0; n < LONG_HOLD; n++) @(negedge clk_i);
        long_hold_req = 1'b0;
        hold_active = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               wav_summaries.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    reset_parser();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_header_checks();
    test_fmt_chunks();
    test_data_chunks();
    test_receiver_hold();
    test_random_files();
    test_final_stretch();
    $display("checked %0d summaries from %0d files, %0d bytes in all",
             results_seen, files_sent, bytes_sent);
    $display("header, fmt and data chunk corners, a long output stall, random and broken files");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
